### sv/qjvs_pkg.sv
// ----------------------------------------------------------------------------
// qjvs_pkg: shared types and constants for quaternion vertex skinning
// Widths of the item fields, action codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package qjvs_pkg;

	localparam int CountW = 9;
	localparam int IdxW   = 8;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_WEIGHT = 1'b1
	} action_t;

	typedef struct packed {
		logic               action;
		logic [IdxW-1:0]    joint_sel;
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
		logic signed [31:0] rot_w;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic [30:0]        bias;
		logic               last_weight;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               bad_joint;
	} out_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -80'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		if (v > 50'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
		if (v < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
		return v[47:0];
	endfunction

endpackage

### sv/qjvs_if.sv
// ----------------------------------------------------------------------------
// qjvs_if: valid/ready channel
// Carries one payload beat per handshake.
// ----------------------------------------------------------------------------
interface qjvs_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/qjvs_mac.sv
// ----------------------------------------------------------------------------
// qjvs_mac: shared multiply-accumulate unit
// One 33x33 multiply per cycle, registered, then summed into a wide register.
// ----------------------------------------------------------------------------
module qjvs_mac
	import qjvs_pkg::*;
(
	input  logic               clk,
	input  logic               clr,
	input  logic               en,
	input  logic               sub,
	input  logic               fl2,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [79:0] acc_q
);
	logic signed [65:0] p_s1;
	logic               sub_s1, fl2_s1, en_s1;
	logic signed [79:0] term;

	always_comb begin
		term = fl2_s1 ? 80'(p_s1 >>> 2) : 80'(p_s1);
		if (sub_s1) term = -term;
	end

	always_ff @(posedge clk) begin
		p_s1   <= a * b;
		sub_s1 <= sub;
		fl2_s1 <= fl2;
		en_s1  <= en;
		if (clr) acc_q <= '0;
		else if (en_s1) acc_q <= acc_q + term;
	end
endmodule

### sv/qjvs_core.sv
// ----------------------------------------------------------------------------
// qjvs_core: skinning sequencer
// Joint table, micro-op sequencer over the shared MAC, vertex accumulators.
// ----------------------------------------------------------------------------
module qjvs_core
	import qjvs_pkg::*;
#(
	parameter int MAX_JOINTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CountW-1:0] joint_count,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);
	localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

	typedef enum logic [2:0] {IDLE, RD, STEP, DRAIN, FIN, EMIT} state_t;
	state_t state_q;

	logic [127:0] rot_mem [MAX_JOINTS];
	logic [95:0]  pos_mem [MAX_JOINTS];
	logic [127:0] rot_q;
	logic [95:0]  pos_q;
	in_item_t     it_q;
	logic [5:0]   op_q;
	logic signed [32:0] t_q [4];
	logic signed [31:0] r_q [3];
	logic signed [47:0] sum_q [3];
	logic               err_q;

	logic               clr, en, sub, fl2;
	logic signed [32:0] ma, mb;
	logic signed [79:0] acc;
	logic signed [32:0] qx, qy, qz, qw;
	logic signed [32:0] vx, vy, vz;
	logic signed [31:0] fin;
	logic signed [79:0] rnd;
	logic [1:0]         grp;
	logic [2:0]         k;
	logic               valid_j;
	logic [AW-1:0]      ja;

	qjvs_mac u_mac (.clk, .clr, .en, .sub, .fl2, .a(ma), .b(mb), .acc_q(acc));

	assign qx = 33'(signed'(rot_q[31:0]));
	assign qy = 33'(signed'(rot_q[63:32]));
	assign qz = 33'(signed'(rot_q[95:64]));
	assign qw = 33'(signed'(rot_q[127:96]));
	assign vx = 33'(it_q.vec_x);
	assign vy = 33'(it_q.vec_y);
	assign vz = 33'(it_q.vec_z);
	assign ja = AW'(it_q.joint_sel);
	assign valid_j = (32'(it_q.joint_sel) < 32'(joint_count)) &&
		(32'(it_q.joint_sel) < MAX_JOINTS);
	assign rnd = (acc + 80'sd134217728) >>> 28;
	assign fin = sat32(rnd);
	// ops 0..27: four per component (t: w,x,y,z; r: x,y,z), 28..30: position*bias
	assign grp = op_q[1:0];
	assign k = 3'(op_q >> 2);

	always_comb begin
		ma = '0; mb = '0; sub = 1'b0; fl2 = 1'b1;
		en = (state_q == STEP);
		clr = 1'b0;
		case (k)
			3'd0: case (grp)
				2'd0: begin ma = qx; mb = vx; sub = 1'b1; end
				2'd1: begin ma = qy; mb = vy; sub = 1'b1; end
				2'd2: begin ma = qz; mb = vz; sub = 1'b1; end
				default: en = 1'b0;
			endcase
			3'd1: case (grp)
				2'd0: begin ma = qw; mb = vx; end
				2'd1: begin ma = qy; mb = vz; end
				2'd2: begin ma = qz; mb = vy; sub = 1'b1; end
				default: en = 1'b0;
			endcase
			3'd2: case (grp)
				2'd0: begin ma = qw; mb = vy; end
				2'd1: begin ma = qz; mb = vx; end
				2'd2: begin ma = qx; mb = vz; sub = 1'b1; end
				default: en = 1'b0;
			endcase
			3'd3: case (grp)
				2'd0: begin ma = qw; mb = vz; end
				2'd1: begin ma = qx; mb = vy; end
				2'd2: begin ma = qy; mb = vx; sub = 1'b1; end
				default: en = 1'b0;
			endcase
			3'd4: case (grp)
				2'd0: begin ma = t_q[0]; mb = qx; sub = 1'b1; end
				2'd1: begin ma = t_q[1]; mb = qw; end
				2'd2: begin ma = t_q[2]; mb = qz; sub = 1'b1; end
				default: begin ma = t_q[3]; mb = qy; end
			endcase
			3'd5: case (grp)
				2'd0: begin ma = t_q[0]; mb = qy; sub = 1'b1; end
				2'd1: begin ma = t_q[1]; mb = qz; end
				2'd2: begin ma = t_q[2]; mb = qw; end
				default: begin ma = t_q[3]; mb = qx; sub = 1'b1; end
			endcase
			3'd6: case (grp)
				2'd0: begin ma = t_q[0]; mb = qz; sub = 1'b1; end
				2'd1: begin ma = t_q[1]; mb = qy; sub = 1'b1; end
				2'd2: begin ma = t_q[2]; mb = qx; end
				default: begin ma = t_q[3]; mb = qw; end
			endcase
			default: begin
				fl2 = 1'b0;
				mb = {2'b00, it_q.bias};
				case (grp)
					2'd0: ma = 33'(signed'(pos_q[31:0])) + 33'(r_q[0]);
					2'd1: ma = 33'(signed'(pos_q[63:32])) + 33'(r_q[1]);
					default: ma = 33'(signed'(pos_q[95:64])) + 33'(r_q[2]);
				endcase
			end
		endcase
		if (state_q == FIN || state_q == RD) begin
			en = 1'b0;
			clr = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && in_valid && in_data.action == ACT_LOAD &&
				32'(in_data.joint_sel) < MAX_JOINTS) begin
			rot_mem[AW'(in_data.joint_sel)] <= {in_data.rot_w, in_data.rot_z,
				in_data.rot_y, in_data.rot_x};
			pos_mem[AW'(in_data.joint_sel)] <= {in_data.vec_z, in_data.vec_y,
				in_data.vec_x};
		end
		rot_q <= rot_mem[ja];
		pos_q <= pos_mem[ja];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			op_q      <= '0;
			err_q     <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end else begin
			if (out_valid && out_ready && state_q != EMIT) out_valid <= 1'b0;
			case (state_q)
				IDLE: if (in_valid && in_data.action == ACT_WEIGHT) begin
					it_q    <= in_data;
					state_q <= RD;
				end
				RD: begin
					op_q <= '0;
					if (valid_j) state_q <= STEP;
					else begin
						err_q   <= 1'b1;
						state_q <= it_q.last_weight ? EMIT : IDLE;
					end
				end
				STEP: begin
					// end of a group: wait out the MAC pipeline
					if (grp == 2'd3 || (k < 3'd4 && grp == 2'd2) || k == 3'd7)
						state_q <= DRAIN;
					else op_q <= op_q + 6'd1;
				end
				DRAIN: state_q <= FIN;
				FIN: begin
					case (k)
						3'd0, 3'd1, 3'd2, 3'd3: t_q[k[1:0]] <= 33'(fin);
						3'd4, 3'd5, 3'd6: r_q[2'(k - 3'd4)] <= fin;
						default: begin
							sum_q[grp] <= sat48(50'(sum_q[grp]) +
								50'((acc + 80'sd536870912) >>> 30));
						end
					endcase
					if (k == 3'd7 && grp == 2'd2)
						state_q <= it_q.last_weight ? EMIT : IDLE;
					else if (k == 3'd7) begin
						op_q <= op_q + 6'd1;
						state_q <= STEP;
					end else begin
						op_q <= {1'b0, k + 3'd1, 2'd0};
						state_q <= STEP;
					end
				end
				EMIT: if (!out_valid || out_ready) begin
					out_valid          <= 1'b1;
					out_data.out_x     <= sat32(80'(sum_q[0]));
					out_data.out_y     <= sat32(80'(sum_q[1]));
					out_data.out_z     <= sat32(80'(sum_q[2]));
					out_data.bad_joint <= err_q;
					for (int i = 0; i < 3; i++) sum_q[i] <= '0;
					err_q   <= 1'b0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == IDLE);
endmodule

### sv/quaternion_joint_vertex_skinning_top.sv
// ----------------------------------------------------------------------------
// quaternion_joint_vertex_skinning_top: joint-table vertex skinning
// Rotates weight offsets by joint quaternions and blends them per vertex.
// ----------------------------------------------------------------------------
// channel  dir  beat
// in       in   one load or weight item
// out      out  one skinned vertex
// cfg      in   joint_count
// A load writes the joint table straight from its beat. A weight holds the input
// after its beat for one table read, then 27 products on the single shared 33x33
// multiplier in ten groups, each group passing a drain state and a store state.
// An invalid joint skips the products: the read state flags it and goes on.
// A last weight adds an emit state, held while the output register is full.
// Reset clears control and accumulators; the joint table is not cleared.
module quaternion_joint_vertex_skinning_top
	import qjvs_pkg::*;
#(
	parameter int MAX_JOINTS = 256
) (
	input logic clk,
	input logic arst_n,
	qjvs_if.sink   in,
	qjvs_if.source out,
	qjvs_if.sink   cfg
);
	logic [CountW-1:0] joint_count_q;
	in_item_t  in_item;
	out_item_t out_item;

	assign in_item  = in.data;
	assign out.data = out_item;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) joint_count_q <= CountW'(256);
		else if (cfg.valid) joint_count_q <= cfg.data[CountW-1:0];
	end

	qjvs_core #(.MAX_JOINTS(MAX_JOINTS)) u_core (
		.clk, .arst_n, .joint_count(joint_count_q),
		.in_valid(in.valid), .in_ready(in.ready), .in_data(in_item),
		.out_valid(out.valid), .out_ready(out.ready), .out_data(out_item)
	);
endmodule

### sv/qjvs_checker.sv
// ----------------------------------------------------------------------------
// qjvs_checker: port-level checks
// Handshake and sequencing properties of the skinning block.
// ----------------------------------------------------------------------------
module qjvs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !in_ready |=> !in_ready || out_valid)
		else $error("busy");
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready)) else $error("emit while idle");
endmodule

bind quaternion_joint_vertex_skinning_top qjvs_checker u_chk (
	.clk, .arst_n, .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready)
);
